/* rtl/core/sdu_pkg.sv */
// ----------------------------------------------------------------------------
// sdu_pkg: shared types and constants of the SSE diagonal update core
// Payload structs, decoded job format, configuration record and helpers.
// ----------------------------------------------------------------------------
package sdu_pkg;

    localparam int SITES_DEF   = 16;
    localparam int SLOTS_DEF   = 2048;
    localparam int COUNT_LIMIT = 4095;
    localparam int OP_W        = 6;
    localparam int COUNT_W     = 12;
    localparam int SPIN_W      = 16;
    localparam int RSITE_W     = 4;
    localparam int SITE_W      = 6;
    localparam int QDEPTH      = 2;

    localparam logic [31:0] ACCEPT_WEIGHT_RST = 32'd2673869;
    localparam logic [31:0] FIELD_SHARE_RST   = 32'd926365495;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SLOT = 1'b1;

    localparam logic CFG_ACCEPT_WEIGHT = 1'b0;
    localparam logic CFG_FIELD_SHARE   = 1'b1;

    typedef enum logic [1:0] {
        KIND_IDENT,
        KIND_DIAG,
        KIND_FLIP,
        KIND_BOND
    } t_sdu_kind;

    typedef struct packed {
        logic                 cmd;
        logic [OP_W-1:0]      op_in;
        logic [31:0]          rand_accept;
        logic [RSITE_W-1:0]   rand_site;
        logic [31:0]          rand_kind;
        logic [SPIN_W-1:0]    spin_load;
        logic [COUNT_W-1:0]   identity_load;
    } t_sdu_in;

    typedef struct packed {
        logic [OP_W-1:0]      op_out;
        logic [COUNT_W-1:0]   identity_count;
        logic [SPIN_W-1:0]    spin_word;
    } t_sdu_out;

    typedef struct packed {
        logic [31:0] accept_weight;
        logic [31:0] field_share;
    } t_sdu_cfg;

    // Decoded slot, everything that does not depend on the running state
    typedef struct packed {
        logic                 cmd;
        t_sdu_kind            kind;
        logic [OP_W-1:0]      op;
        logic [SITE_W-1:0]    op_site;
        logic                 op_site_ok;
        logic [31:0]          rand_accept;
        logic                 new_ok;
        logic [SITE_W-1:0]    new_site;
        logic [SITE_W-1:0]    new_left;
        logic                 pick_field;
        logic [OP_W-1:0]      field_op;
        logic [OP_W-1:0]      bond_op;
        logic [15:0]          rem_hi;
        logic [SPIN_W-1:0]    spin_load;
        logic [COUNT_W-1:0]   count_load;
    } t_sdu_job;

    // Quotient by three through the reciprocal 43/128, exact below 128
    function automatic logic [4:0] div3(input logic [OP_W-1:0] x);
        logic [12:0] p;
        p = 13'(x) * 13'd43;
        return p[11:7];
    endfunction

endpackage

/* rtl/core/sse_diagonal_update_core.sv */
// ----------------------------------------------------------------------------
// sse_diagonal_update_core: SSE diagonal update for a transverse-field chain
// From input transaction to result valid: front register, queue entry,
// output register. Throughput: one transaction per cycle while the result
// receiver is ready, set by the spin/identity-count loop in the back stage.
// Reset (synchronous, active low): spins and identity count clear, the queue
// empties, configuration returns to its defaults; no clearing pass.
// ----------------------------------------------------------------------------
module sse_diagonal_update_core #(
    parameter int SITES = sdu_pkg::SITES_DEF,
    parameter int SLOTS = sdu_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sdu_pkg::t_sdu_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sdu_pkg::t_sdu_out o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import sdu_pkg::*;

    localparam int COUNT_CAP = (SLOTS < COUNT_LIMIT) ? SLOTS : COUNT_LIMIT;

    t_sdu_cfg r_cfg;
    logic     f_valid;
    logic     f_ready;
    t_sdu_job f_job;
    logic     q_valid;
    logic     q_ready;
    t_sdu_job q_job;

    // The user makes configuration changes only while idle (not enforced); always take a write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accept_weight <= ACCEPT_WEIGHT_RST;
            r_cfg.field_share   <= FIELD_SHARE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ACCEPT_WEIGHT: r_cfg.accept_weight <= i_cfg_data;
                CFG_FIELD_SHARE:   r_cfg.field_share   <= i_cfg_data;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // Front: decode the slot and precompute everything free of running state
    sdu_front #(
        .SITES (SITES),
        .SLOTS (SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in),
        .i_cfg       (r_cfg),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    // Queue: decouple decode from execute
    sdu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_job   (f_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_job    (q_job)
    );

    // Back: advance spins and identity count, drive the result register
    sdu_back #(
        .SITES (SITES),
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .i_cfg       (r_cfg),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out)
    );

    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.identity_count <= COUNT_W'(COUNT_CAP))
        else $error("result identity count above its bound");

    a_out_spins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out.spin_word) >> SITES) == 32'd0)
        else $error("result spin word has bits beyond the chain");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(q_valid))
        else $error("result appeared without a queued job");

endmodule

/* rtl/core/sdu_front.sv */
// ----------------------------------------------------------------------------
// sdu_front: accept and classify stage
// Decodes the operator code, precomputes state-free compares and the remove
// product, and holds the decoded job until the queue takes it.
// ----------------------------------------------------------------------------
module sdu_front #(
    parameter int SITES = sdu_pkg::SITES_DEF,
    parameter int SLOTS = sdu_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sdu_pkg::t_sdu_in  i_item,
    input  sdu_pkg::t_sdu_cfg i_cfg,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output sdu_pkg::t_sdu_job o_job
);
    import sdu_pkg::*;

    localparam int COUNT_CAP = (SLOTS < COUNT_LIMIT) ? SLOTS : COUNT_LIMIT;
    localparam logic [COUNT_W-1:0] CAP_W = COUNT_W'(COUNT_CAP);

    logic      r_valid;
    t_sdu_job  r_job;
    t_sdu_job  n_job;
    logic [4:0]  quo;
    logic [1:0]  rem;
    logic [63:0] rem_prod;
    logic [SITE_W-1:0] rs_ext;

    assign o_ready     = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_comb begin
        quo      = div3(i_item.op_in);
        rem      = 2'(i_item.op_in - 6'd3 * 6'(quo));
        rem_prod = 64'(i_item.rand_accept) * 64'(i_cfg.accept_weight);
        rs_ext   = {2'b00, i_item.rand_site};

        n_job.cmd = i_item.cmd;
        n_job.op  = i_item.op_in;
        if (i_item.op_in == '0) begin
            n_job.kind = KIND_IDENT;
        end else if (rem == 2'd1) begin
            n_job.kind = KIND_DIAG;
        end else if (rem == 2'd2) begin
            n_job.kind = KIND_FLIP;
        end else begin
            n_job.kind = KIND_BOND;
        end
        n_job.op_site     = (rem == 2'd0) ? 6'(quo) - 6'd1 : 6'(quo);
        n_job.op_site_ok  = {26'b0, n_job.op_site} < 32'(SITES);
        n_job.rand_accept = i_item.rand_accept;
        n_job.new_ok      = {26'b0, rs_ext} < 32'(SITES);
        n_job.new_site    = rs_ext;
        n_job.new_left    = (rs_ext == '0) ? 6'(SITES - 1) : rs_ext - 6'd1;
        n_job.pick_field  = i_item.rand_kind < i_cfg.field_share;
        n_job.field_op    = 6'd3 * rs_ext + 6'd1;
        n_job.bond_op     = 6'd3 * rs_ext + 6'd3;
        n_job.rem_hi      = rem_prod[63:48];
        n_job.spin_load   = i_item.spin_load;
        n_job.count_load  = (i_item.identity_load > CAP_W) ? CAP_W : i_item.identity_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_job <= n_job;
        end
    end

endmodule

/* rtl/core/sdu_queue.sv */
// ----------------------------------------------------------------------------
// sdu_queue: short job queue between front and back
// Two-entry FIFO of decoded jobs so either side can stall on its own.
// ----------------------------------------------------------------------------
module sdu_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  sdu_pkg::t_sdu_job i_push_job,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output sdu_pkg::t_sdu_job o_pop_job
);
    import sdu_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_sdu_job         r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count < CNT_W'(QDEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

/* rtl/core/sdu_back.sv */
// ----------------------------------------------------------------------------
// sdu_back: execute stage
// Holds the spin word and identity count, applies one job per cycle unless
// a held result stalls it, and writes the result into the output register.
// ----------------------------------------------------------------------------
module sdu_back #(
    parameter int SITES = sdu_pkg::SITES_DEF,
    parameter int SLOTS = sdu_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  sdu_pkg::t_sdu_job i_job,
    input  sdu_pkg::t_sdu_cfg i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output sdu_pkg::t_sdu_out o_item
);
    import sdu_pkg::*;

    localparam int COUNT_CAP = (SLOTS < COUNT_LIMIT) ? SLOTS : COUNT_LIMIT;
    localparam logic [COUNT_W-1:0] CAP_W = COUNT_W'(COUNT_CAP);
    localparam int IDX_W = $clog2(SITES);

    logic [SITES-1:0]   r_spin;
    logic [SITES-1:0]   n_spin;
    logic [COUNT_W-1:0] r_idle;
    logic [COUNT_W-1:0] n_idle;
    logic [OP_W-1:0]    n_op;
    logic               r_valid;
    t_sdu_out           r_item;
    t_sdu_out           n_item;
    logic               pop;
    logic [SITES-1:0]   load_word;
    logic [SPIN_W-1:0]  spin_view;
    logic [43:0]        ins_prod;
    logic               ins_ok;
    logic               bond_eq;

    assign o_job_ready = !r_valid || i_ready;
    assign pop         = i_job_valid && o_job_ready;
    assign o_valid     = r_valid;
    assign o_item      = r_item;

    for (genvar i = 0; i < SITES; i++) begin : g_load
        if (i < SPIN_W) begin : g_in
            assign load_word[i] = i_job.spin_load[i];
        end else begin : g_zero
            assign load_word[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < SPIN_W; i++) begin : g_view
        if (i < SITES) begin : g_bit
            assign spin_view[i] = n_spin[i];
        end else begin : g_zero
            assign spin_view[i] = 1'b0;
        end
    end

    always_comb begin
        ins_prod = 44'(i_job.rand_accept) * 44'(r_idle);
        ins_ok   = (r_idle == '0) || ({4'b0, ins_prod[43:16]} < i_cfg.accept_weight);
        bond_eq  = r_spin[i_job.new_site[IDX_W-1:0]] == r_spin[i_job.new_left[IDX_W-1:0]];
        n_spin   = r_spin;
        n_idle   = r_idle;
        n_op     = '0;
        if (i_job.cmd == CMD_LOAD) begin
            n_spin = load_word;
            n_idle = i_job.count_load;
        end else if (i_job.kind == KIND_IDENT) begin
            if (ins_ok && i_job.new_ok) begin
                if (i_job.pick_field) begin
                    n_op = i_job.field_op;
                end else if (bond_eq) begin
                    n_op = i_job.bond_op;
                end
                if ((n_op != '0) && (r_idle != '0)) begin
                    n_idle = r_idle - 1'b1;
                end
            end
        end else begin
            n_op = i_job.op;
            if (i_job.op_site_ok) begin
                if (i_job.kind == KIND_FLIP) begin
                    n_spin = r_spin ^ ({{(SITES-1){1'b0}}, 1'b1} << i_job.op_site[IDX_W-1:0]);
                end else if (i_job.rem_hi <= 16'(r_idle)) begin
                    n_op = '0;
                    if (r_idle < CAP_W) begin
                        n_idle = r_idle + 1'b1;
                    end
                end
            end
        end
        n_item.op_out         = n_op;
        n_item.identity_count = n_idle;
        n_item.spin_word      = spin_view;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin  <= '0;
            r_idle  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_spin <= n_spin;
                r_idle <= n_idle;
            end
            if (o_job_ready) begin
                r_valid <= i_job_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= n_item;
        end
    end

    a_idle_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idle <= CAP_W)
        else $error("identity count above its bound");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && (i_job.cmd == CMD_LOAD) |=> (r_item.op_out == '0) && (r_idle == r_item.identity_count))
        else $error("load transaction result does not match loaded state");

    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> $stable(r_spin) && $stable(r_idle))
        else $error("state advanced while result was held");

endmodule

/* tb/sdu_update_checker.sv */
// ----------------------------------------------------------------------------
// sdu_update_checker: result predictor and comparator for the diagonal update
// Watches the slot, result and register channels of the core, keeps its own
// copy of spins, identity count and weights, predicts one result per accepted
// slot transaction and compares every accepted result with the oldest one.
// ----------------------------------------------------------------------------
module sdu_update_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  sdu_pkg::t_sdu_in  i_in,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  sdu_pkg::t_sdu_out i_out,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output int                o_errors,
    output int                o_pending
);
    import sdu_pkg::*;

    localparam int SITES     = SITES_DEF;
    localparam int COUNT_CAP = (SLOTS_DEF < COUNT_LIMIT) ? SLOTS_DEF : COUNT_LIMIT;

    // Residue of an operator code modulo three
    localparam int RES_BOND = 0;
    localparam int RES_DIAG = 1;
    localparam int RES_FLIP = 2;

    logic [31:0]        weight;
    logic [31:0]        share;
    logic [SPIN_W-1:0]  spins;
    logic [COUNT_W-1:0] free_slots;
    t_sdu_out           predicted_updates[$];
    t_sdu_out           oldest;
    int                 error_count = 0;

    assign o_errors = error_count;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    // Advance the local state by one transaction and return its result
    function automatic t_sdu_out predict_update(input t_sdu_in it);
        t_sdu_out    res;
        int unsigned rs;
        int unsigned left;
        int unsigned site;
        int unsigned residue;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic        placed;
        res    = '0;
        placed = 1'b0;
        if (it.cmd == CMD_LOAD) begin
            // the spin word is exactly SITES wide, so no mask is needed
            spins      = it.spin_load;
            free_slots = (it.identity_load > COUNT_CAP) ? COUNT_W'(COUNT_CAP)
                                                         : it.identity_load;
        end else if (it.op_in == OP_W'(KIND_IDENT)) begin
            rs   = it.rand_site;
            left = (rs == 0) ? SITES - 1 : rs - 1;
            lhs  = 64'(it.rand_accept) * 64'(free_slots);
            rhs  = 64'(weight) << 16;
            if ((free_slots == '0 || lhs < rhs) && rs < SITES) begin
                if (it.rand_kind < share) begin
                    res.op_out = OP_W'(3 * rs + 1);
                    placed     = 1'b1;
                end else if (spins[rs] == spins[left]) begin
                    res.op_out = OP_W'(3 * rs + 3);
                    placed     = 1'b1;
                end
            end
            if (placed && free_slots != '0)
                free_slots--;
        end else begin
            residue    = it.op_in % 3;
            site       = (residue == RES_BOND) ? it.op_in / 3 - 1 : it.op_in / 3;
            res.op_out = it.op_in;
            if (site < SITES) begin
                if (residue == RES_FLIP) begin
                    spins[site] = ~spins[site];
                end else begin
                    lhs = 64'(it.rand_accept) * 64'(weight);
                    rhs = (64'(free_slots) + 64'd1) << 48;
                    if (lhs < rhs) begin
                        res.op_out = OP_W'(KIND_IDENT);
                        if (free_slots < COUNT_CAP)
                            free_slots++;
                    end
                end
            end
        end
        res.identity_count = free_slots;
        res.spin_word      = spins;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            weight     = ACCEPT_WEIGHT_RST;
            share      = FIELD_SHARE_RST;
            spins      = '0;
            free_slots = '0;
            predicted_updates.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ACCEPT_WEIGHT)
                    weight = i_cfg_data;
                else
                    share = i_cfg_data;
            end
            // a result can never belong to a slot accepted at the same edge
            if (i_out_valid && i_out_ready) begin
                if (predicted_updates.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'd0,
                                    32'(i_out.op_out));
                end else begin
                    oldest = predicted_updates.pop_front();
                    if (i_out.op_out !== oldest.op_out)
                        report_mismatch("op_out", 32'(oldest.op_out), 32'(i_out.op_out));
                    if (i_out.identity_count !== oldest.identity_count)
                        report_mismatch("identity_count", 32'(oldest.identity_count),
                                        32'(i_out.identity_count));
                    if (i_out.spin_word !== oldest.spin_word)
                        report_mismatch("spin_word", 32'(oldest.spin_word),
                                        32'(i_out.spin_word));
                end
            end
            if (i_in_valid && i_in_ready)
                predicted_updates.push_back(predict_update(i_in));
        end
        o_pending <= predicted_updates.size();
    end

endmodule

/* tb/sse_diagonal_update_core_tb.sv */
// ----------------------------------------------------------------------------
// sse_diagonal_update_core_tb: stimulus and verdict for the diagonal update
// Drives load and slot transactions into the core under several weight and
// field-share settings, with random idling on both sides, one long result
// hold-off and calm stretches. A checker beside the core predicts each result.
// ----------------------------------------------------------------------------
module sse_diagonal_update_core_tb;
    import sdu_pkg::*;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 315;
    localparam int TAIL_CYCLES  = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int IDLE_PCT     = 21;
    // receiver pressure and calm windows, placed by accepted results; hold length in cycles
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 160;
    localparam int CALM_FROM    = 1100;
    localparam int CALM_TO      = 1400;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_sdu_in     in_data   = '0;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_sdu_out    out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = CFG_ACCEPT_WEIGHT;
    logic [31:0] cfg_data  = '0;
    logic        cfg_ready;

    int chk_errors;
    int chk_pending;
    int cycle_count  = 0;
    int results_seen = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    bit sender_calm  = 1'b0;

    always #10 clk = ~clk;

    sse_diagonal_update_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sdu_update_checker u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    // ------------------------------------------------------------------
    // Operator code helpers: diagonal field, flip field and bond on site s
    // ------------------------------------------------------------------
    function automatic logic [OP_W-1:0] diag_op(input int s);
        return OP_W'(3 * s + 1);
    endfunction

    function automatic logic [OP_W-1:0] flip_op(input int s);
        return OP_W'(3 * s + 2);
    endfunction

    function automatic logic [OP_W-1:0] bond_op(input int s);
        return OP_W'(3 * s + 3);
    endfunction

    // Build a slot transaction; fields that a slot ignores carry noise
    function automatic t_sdu_in slot_item(input logic [OP_W-1:0] op, input logic [31:0] ru,
                                          input logic [RSITE_W-1:0] rs,
                                          input logic [31:0] rk);
        t_sdu_in it;
        it.cmd           = CMD_SLOT;
        it.op_in         = op;
        it.rand_accept   = ru;
        it.rand_site     = rs;
        it.rand_kind     = rk;
        it.spin_load     = SPIN_W'($urandom);
        it.identity_load = COUNT_W'($urandom);
        return it;
    endfunction

    // Build a load transaction; slot fields carry noise
    function automatic t_sdu_in load_item(input logic [SPIN_W-1:0] spin,
                                          input logic [COUNT_W-1:0] count);
        t_sdu_in it;
        it.cmd           = CMD_LOAD;
        it.op_in         = OP_W'($urandom);
        it.rand_accept   = $urandom;
        it.rand_site     = RSITE_W'($urandom);
        it.rand_kind     = $urandom;
        it.spin_load     = spin;
        it.identity_load = count;
        return it;
    endfunction

    // Identity counts cluster around zero, the slot bound and the field top
    function automatic logic [COUNT_W-1:0] rand_count();
        case ($urandom_range(3))
            0:       return COUNT_W'($urandom_range(8));
            1:       return COUNT_W'($urandom_range(SLOTS_DEF + 2, SLOTS_DEF - 2));
            2:       return COUNT_W'($urandom_range(COUNT_LIMIT, COUNT_LIMIT - 3));
            default: return COUNT_W'($urandom);
        endcase
    endfunction

    // Mostly slots of a plausible sweep, a few stray loads and invalid codes
    function automatic t_sdu_in rand_item();
        int unsigned     pick;
        logic [OP_W-1:0] op;
        logic [31:0]     ru;
        logic [31:0]     rk;
        pick = $urandom_range(99);
        if (pick < 3)
            return load_item(SPIN_W'($urandom), rand_count());
        pick = $urandom_range(99);
        if (pick < 45)
            op = OP_W'(KIND_IDENT);
        else if (pick < 85)
            op = OP_W'($urandom_range(48, 1));
        else if (pick < 95)
            op = OP_W'($urandom_range(63, 49));
        else
            op = OP_W'($urandom);
        // small draws are needed for inserts at large counts and removes
        pick = $urandom_range(99);
        if (pick < 40)
            ru = $urandom >> $urandom_range(31);
        else if (pick < 45)
            ru = '0;
        else if (pick < 50)
            ru = '1;
        else
            ru = $urandom;
        pick = $urandom_range(99);
        if (pick < 10)
            rk = '0;
        else if (pick < 20)
            rk = '1;
        else
            rk = $urandom;
        return slot_item(op, ru, RSITE_W'($urandom), rk);
    endfunction

    // ------------------------------------------------------------------
    // Offer one transaction. Drop valid only when a gap is taken, so that
    // back-to-back transactions keep valid high without a glitch.
    // ------------------------------------------------------------------
    task automatic offer(input t_sdu_in item);
        if (!sender_calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    // Write both registers back to back, holding valid across the pair
    task automatic write_config(input logic [31:0] weight, input logic [31:0] share);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ACCEPT_WEIGHT;
        cfg_data  <= weight;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_FIELD_SHARE;
        cfg_data  <= share;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every predicted result has been seen
    task automatic wait_drained();
        do @(posedge clk); while (chk_pending != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, one long hold-off while the sender keeps
    // offering, and a calm window with ready held high.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen == HOLD_AT) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
        if (out_valid && out_ready)
            results_seen <= results_seen + 1;
    end

    // Watchdog: end the run if the core stops making progress
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed cases, then random phases
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] weights [PHASES];
        logic [31:0] shares  [PHASES];

        weights[0] = $urandom_range(32'h0040_0000);
        shares[0]  = $urandom;
        weights[1] = '0;                       // removal always wins
        shares[1]  = '0;                       // only bonds get inserted
        weights[2] = '1;
        shares[2]  = '1;
        weights[3] = $urandom;
        shares[3]  = 32'h8000_0000;
        weights[4] = ACCEPT_WEIGHT_RST >> 4;
        shares[4]  = $urandom;
        weights[5] = ACCEPT_WEIGHT_RST;
        shares[5]  = FIELD_SHARE_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run on the reset weights
        offer(load_item(16'hFFFF, 12'hFFF));               // count above the bound clamps
        offer(slot_item(OP_W'(KIND_IDENT), '0, 4'd0, '0));  // sure insert of a field
        offer(slot_item(OP_W'(KIND_IDENT), '1, 4'd15, '1)); // draw too large, stays empty
        offer(slot_item(OP_W'(KIND_IDENT), '0, 4'd0, '1));  // bond across the periodic wrap
        offer(slot_item(OP_W'(KIND_IDENT), '0, 4'd15, '1)); // bond on the top site
        offer(slot_item(diag_op(0), '0, 4'd3, '0));         // remove a diagonal field
        offer(slot_item(bond_op(15), '1, 4'd0, '0));        // bond removal with the largest draw
        offer(slot_item(flip_op(0), '1, 4'd9, '1));         // flip the bottom spin
        offer(slot_item(flip_op(15), '0, 4'd2, '0));        // flip the top spin
        offer(slot_item(diag_op(16), '0, 4'd0, '0));        // site out of range passes through
        offer(slot_item(flip_op(16), '0, 4'd0, '0));
        offer(slot_item(bond_op(20), '0, 4'd0, '0));        // all-ones operator code
        offer(load_item(16'h0001, 12'd2));
        offer(slot_item(OP_W'(KIND_IDENT), '0, 4'd0, '1));  // unequal neighbours, no bond
        offer(slot_item(OP_W'(KIND_IDENT), '0, 4'd1, '1));
        offer(slot_item(OP_W'(KIND_IDENT), '0, 4'd2, '1));  // equal neighbours, bond placed
        offer(slot_item(OP_W'(KIND_IDENT), '0, 4'd5, '0));  // count reaches zero
        offer(slot_item(OP_W'(KIND_IDENT), '1, 4'd7, '0));  // empty count always accepts
        offer(slot_item(bond_op(0), '0, 4'd0, '0));         // removal raises the count
        offer(load_item(16'hA5A5, 12'd2048));
        offer(slot_item(diag_op(1), '0, 4'd0, '0));         // removal holds at the bound
        offer(slot_item(OP_W'(KIND_IDENT), '1, 4'd3, '1));
        offer(load_item(16'h0000, 12'd2049));
        offer(slot_item(flip_op(1), '1, 4'd0, '0));
        in_valid <= 1'b0;
        wait_drained();

        // Random phases; the core is idle before each register write
        for (int p = 0; p < PHASES; p++) begin
            sender_calm = (p == 2);
            write_config(weights[p], shares[p]);
            offer(load_item(SPIN_W'($urandom), rand_count()));
            for (int i = 0; i < PHASE_ITEMS; i++)
                offer(rand_item());
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (chk_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/sdu_pkg.sv
rtl/core/sdu_front.sv
rtl/core/sdu_queue.sv
rtl/core/sdu_back.sv
rtl/core/sse_diagonal_update_core.sv
tb/sdu_update_checker.sv
tb/sse_diagonal_update_core_tb.sv
